// File: rtl/bfw_pkg.sv
// ----------------------------------------------------------------------------
// bfw_pkg
// Shared types and fixed constants of the bilinear flow warp.
// ----------------------------------------------------------------------------
package bfw_pkg;

   localparam int FLOW_BITS      = 20;
   localparam int CFG_BITS       = 10;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [CFG_BITS-1:0] DIM_RESET = 10'd512;

   // stage strobes from the sequencer to the blend datapath
   typedef struct packed {
      logic take_p00;
      logic make_r0;
      logic take_p10;
      logic make_r1;
      logic make_v;
   } blend_ctl_type;

endpackage

// File: rtl/bfw_blend.sv
// ----------------------------------------------------------------------------
// bfw_blend
// Bilinear blend of four neighbours read one by one from the frame store,
// with round half up and saturation of the result.
// ----------------------------------------------------------------------------
module bfw_blend
   import bfw_pkg::*;
#(
   parameter int PIXEL_BITS     = 16,
   parameter int FLOW_FRAC_BITS = 8
) (
   input  logic                      clock,
   input  blend_ctl_type             ctl,
   input  logic [PIXEL_BITS-1:0]     rd_data,
   input  logic [FLOW_FRAC_BITS-1:0] weight_a,
   input  logic [FLOW_FRAC_BITS-1:0] weight_b,
   output logic [PIXEL_BITS-1:0]     result
);

   localparam int P   = PIXEL_BITS;
   localparam int F   = FLOW_FRAC_BITS;
   localparam int R_W = P + F + 2;
   localparam int V_W = R_W + F + 2;

   localparam logic signed [V_W:0] PMAX = (V_W+1)'((64'sd1 <<< (P - 1)) - 64'sd1);
   localparam logic signed [V_W:0] PMIN = -PMAX - (V_W+1)'(1);

   logic signed [P-1:0]   sample;
   logic signed [P-1:0]   p00_ff;
   logic signed [P-1:0]   p10_ff;
   logic signed [P:0]     d_pix;
   logic signed [R_W-1:0] m_row;
   logic signed [R_W-1:0] row_in;
   logic signed [R_W-1:0] r0_ff;
   logic signed [R_W-1:0] r1_ff;
   logic signed [R_W:0]   d_row;
   logic signed [V_W-1:0] m_col;
   logic signed [V_W-1:0] v_in;
   logic signed [V_W-1:0] v_ff;
   logic signed [V_W:0]   rnd_c;
   logic signed [V_W:0]   v_rnd;
   logic signed [V_W:0]   q_full;

   assign sample = $signed(rd_data);

   // row blend: p0*one + (p1 - p0)*a, shared by both rows
   always_comb begin
      if (ctl.make_r0) begin
         d_pix = (P+1)'(sample) - (P+1)'(p00_ff);
         m_row = d_pix * $signed({1'b0, weight_a});
         row_in = (R_W'(p00_ff) <<< F) + m_row;
      end else begin
         d_pix = (P+1)'(sample) - (P+1)'(p10_ff);
         m_row = d_pix * $signed({1'b0, weight_a});
         row_in = (R_W'(p10_ff) <<< F) + m_row;
      end
   end

   assign d_row = (R_W+1)'(r1_ff) - (R_W+1)'(r0_ff);
   assign m_col = d_row * $signed({1'b0, weight_b});
   assign v_in  = (V_W'(r0_ff) <<< F) + m_col;

   always_ff @(posedge clock) begin
      if (ctl.take_p00) begin
         p00_ff <= sample;
      end
      if (ctl.take_p10) begin
         p10_ff <= sample;
      end
      if (ctl.make_r0) begin
         r0_ff <= row_in;
      end
      if (ctl.make_r1) begin
         r1_ff <= row_in;
      end
      if (ctl.make_v) begin
         v_ff <= v_in;
      end
   end

   assign rnd_c  = (V_W+1)'(1) <<< (2 * F - 1);
   assign v_rnd  = (V_W+1)'(v_ff) + rnd_c;
   assign q_full = v_rnd >>> (2 * F);

   always_comb begin
      if (q_full > PMAX) begin
         result = PMAX[P-1:0];
      end else if (q_full < PMIN) begin
         result = PMIN[P-1:0];
      end else begin
         result = q_full[P-1:0];
      end
   end

endmodule

// File: rtl/bilinear_flow_warp.sv
// ----------------------------------------------------------------------------
// bilinear_flow_warp
// Backward warp of one image plane by a per-pixel flow field.
//
// Load the plane first: transfers with req_kind 0 write req_pixel_value into
// the frame store in raster order, wrapping after width*height samples.
// Then send one transfer with req_kind 1 per output pixel, in raster order,
// carrying the Q11.8 flow. Each gives one rsp transfer with the bilinear
// sample (round half up, saturated) and rsp_last_pixel on the plane's end.
// A load transfer writes the store in S_LOAD. A flow transfer steps through
// S_CALC, S_MUL, S_RD0 to S_RD3, S_BL1 and S_BL2; its result enters the
// output register in S_OUT. The four neighbours come one per cycle through
// the single store read port; three multiply stages then blend them.
// The output register lets the next transfer be accepted while a result
// waits; a flow result that finds it still full holds the sequencer until
// rsp_ready. csr writes set frame_width (index 0) and frame_height (1), and
// take effect for transfers accepted from the next cycle on.
// Reset clears the positions and restores 512x512; store contents stay
// undefined until loaded.
// ----------------------------------------------------------------------------
module bilinear_flow_warp
   import bfw_pkg::*;
#(
   parameter int MAX_WIDTH      = 512,
   parameter int MAX_HEIGHT     = 512,
   parameter int PIXEL_BITS     = 16,
   parameter int FLOW_FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic [PIXEL_BITS-1:0]     req_pixel_value,
   input  logic signed [FLOW_BITS-1:0] req_flow_x,
   input  logic signed [FLOW_BITS-1:0] req_flow_y,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PIXEL_BITS-1:0]     rsp_warped_value,
   output logic                      rsp_last_pixel,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   localparam int F         = FLOW_FRAC_BITS;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int WD_W      = $clog2(MAX_WIDTH + 1);
   localparam int HT_W      = $clog2(MAX_HEIGHT + 1);
   localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int POS_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int S_W       = ((POS_W + F > FLOW_BITS) ? POS_W + F : FLOW_BITS) + 2;
   localparam int X_W       = S_W - F;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOAD = 4'd1;
   localparam logic [3:0] S_CALC = 4'd2;
   localparam logic [3:0] S_MUL  = 4'd3;
   localparam logic [3:0] S_RD0  = 4'd4;
   localparam logic [3:0] S_RD1  = 4'd5;
   localparam logic [3:0] S_RD2  = 4'd6;
   localparam logic [3:0] S_RD3  = 4'd7;
   localparam logic [3:0] S_BL1  = 4'd8;
   localparam logic [3:0] S_BL2  = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   function automatic logic signed [X_W-1:0] clamp_pos(
      input logic signed [X_W-1:0] v,
      input logic signed [X_W-1:0] hi
   );
      logic signed [X_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // control state
   logic [3:0]            state_ff, state_in;
   logic [CFG_BITS-1:0]   width_ff, height_ff;
   logic [ADDR_W-1:0]     load_pos_ff, load_pos_in;
   logic [COL_W-1:0]      out_col_ff, out_col_in;
   logic [ROW_W-1:0]      out_row_ff, out_row_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload
   logic [PIXEL_BITS-1:0]       pix_ff;
   logic signed [FLOW_BITS-1:0] flow_x_ff, flow_y_ff;
   logic [ADDR_W:0]             total_ff;
   logic [COL_W-1:0]            cx0_ff, cx1_ff;
   logic [ROW_W-1:0]            cy0_ff, cy1_ff;
   logic [F-1:0]                a_ff, b_ff;
   logic                        last_ff;
   logic [ADDR_W-1:0]           base0_ff, base1_ff;
   logic [PIXEL_BITS-1:0]       rd_data_ff;
   logic [PIXEL_BITS-1:0]       rsp_value_ff;
   logic                        rsp_last_ff;

   logic [PIXEL_BITS-1:0] store_mem [MEM_DEPTH];

   logic [WD_W-1:0]          w_eff;
   logic [HT_W-1:0]          h_eff;
   logic [WD_W+HT_W-1:0]     total_full;
   logic                     accept;
   logic                     out_free;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ADDR_W:0]          wr_next;
   logic [ADDR_W-1:0]        rd_addr;
   logic [COL_W-1:0]         col_w;
   logic [ROW_W-1:0]         row_w;
   logic                     col_end, row_end;
   logic signed [S_W-1:0]    sx, sy;
   logic signed [X_W-1:0]    x0, y0, w_lim, h_lim;
   logic signed [X_W-1:0]    cx0_full, cx1_full, cy0_full, cy1_full;
   logic [ROW_W+WD_W-1:0]    row_base;
   logic [PIXEL_BITS-1:0]    blend_result;
   blend_ctl_type            blend_ctl;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WD_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WD_W'(MAX_WIDTH);
      end else begin
         w_eff = WD_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HT_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HT_W'(MAX_HEIGHT);
      end else begin
         h_eff = HT_W'(height_ff);
      end
   end

   assign total_full = w_eff * h_eff;
   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // load address with wrap
   assign wr_addr = (ADDR_W+1)'(load_pos_ff) < total_ff ? load_pos_ff : '0;
   assign wr_next = (ADDR_W+1)'(wr_addr) + (ADDR_W+1)'(1);

   // output position, taken as 0 when beyond a reduced size
   assign col_w   = (WD_W'(out_col_ff) >= w_eff) ? '0 : out_col_ff;
   assign row_w   = (HT_W'(out_row_ff) >= h_eff) ? '0 : out_row_ff;
   assign col_end = (WD_W'(col_w) == w_eff - WD_W'(1));
   assign row_end = (HT_W'(row_w) == h_eff - HT_W'(1));

   assign sx    = $signed(S_W'({col_w, {F{1'b0}}})) + S_W'(flow_x_ff);
   assign sy    = $signed(S_W'({row_w, {F{1'b0}}})) + S_W'(flow_y_ff);
   assign x0    = $signed(sx[S_W-1:F]);
   assign y0    = $signed(sy[S_W-1:F]);
   assign w_lim = $signed(X_W'(w_eff) - X_W'(1));
   assign h_lim = $signed(X_W'(h_eff) - X_W'(1));

   assign cx0_full = clamp_pos(x0, w_lim);
   assign cx1_full = clamp_pos(x0 + X_W'(1), w_lim);
   assign cy0_full = clamp_pos(y0, h_lim);
   assign cy1_full = clamp_pos(y0 + X_W'(1), h_lim);

   assign row_base = cy0_ff * w_eff;

   always_comb begin
      case (state_ff)
         S_RD1:   rd_addr = base0_ff + ADDR_W'(cx1_ff);
         S_RD2:   rd_addr = base1_ff + ADDR_W'(cx0_ff);
         S_RD3:   rd_addr = base1_ff + ADDR_W'(cx1_ff);
         default: rd_addr = base0_ff + ADDR_W'(cx0_ff);
      endcase
   end

   always_comb begin
      blend_ctl          = '0;
      blend_ctl.take_p00 = (state_ff == S_RD1);
      blend_ctl.make_r0  = (state_ff == S_RD2);
      blend_ctl.take_p10 = (state_ff == S_RD3);
      blend_ctl.make_r1  = (state_ff == S_BL1);
      blend_ctl.make_v   = (state_ff == S_BL2);
   end

   always_comb begin
      state_in     = state_ff;
      load_pos_in  = load_pos_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = req_kind ? S_CALC : S_LOAD;
            end
         end
         S_LOAD: begin
            load_pos_in = (wr_next >= total_ff) ? '0 : wr_next[ADDR_W-1:0];
            state_in    = S_IDLE;
         end
         S_CALC: begin
            if (col_end) begin
               out_col_in = '0;
               out_row_in = row_end ? '0 : row_w + ROW_W'(1);
            end else begin
               out_col_in = col_w + COL_W'(1);
               out_row_in = row_w;
            end
            state_in = S_MUL;
         end
         S_MUL:   state_in = S_RD0;
         S_RD0:   state_in = S_RD1;
         S_RD1:   state_in = S_RD2;
         S_RD2:   state_in = S_RD3;
         S_RD3:   state_in = S_BL1;
         S_BL1:   state_in = S_BL2;
         S_BL2:   state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= DIM_RESET;
         height_ff    <= DIM_RESET;
         load_pos_ff  <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_FRAME_WIDTH:  width_ff  <= csr_wdata;
               REG_FRAME_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_full[ADDR_W:0];
      if (accept) begin
         pix_ff    <= req_pixel_value;
         flow_x_ff <= req_flow_x;
         flow_y_ff <= req_flow_y;
      end
      if (state_ff == S_CALC) begin
         cx0_ff  <= cx0_full[COL_W-1:0];
         cx1_ff  <= cx1_full[COL_W-1:0];
         cy0_ff  <= cy0_full[ROW_W-1:0];
         cy1_ff  <= cy1_full[ROW_W-1:0];
         a_ff    <= sx[F-1:0];
         b_ff    <= sy[F-1:0];
         last_ff <= col_end && row_end;
      end
      if (state_ff == S_MUL) begin
         base0_ff <= row_base[ADDR_W-1:0];
      end
      if (state_ff == S_RD0) begin
         base1_ff <= (cy1_ff == cy0_ff) ? base0_ff : base0_ff + ADDR_W'(w_eff);
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_value_ff <= blend_result;
         rsp_last_ff  <= last_ff;
      end
   end

   // frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD) begin
         store_mem[wr_addr] <= pix_ff;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   bfw_blend #(
      .PIXEL_BITS     (PIXEL_BITS),
      .FLOW_FRAC_BITS (FLOW_FRAC_BITS)
   ) u_blend (
      .clock    (clock),
      .ctl      (blend_ctl),
      .rd_data  (rd_data_ff),
      .weight_a (a_ff),
      .weight_b (b_ff),
      .result   (blend_result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_warped_value = rsp_value_ff;
   assign rsp_last_pixel   = rsp_last_ff;

   a_flow_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind) |-> ##9 (state_ff == S_OUT))
      else $error("flow transfer did not reach the output stage on time");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output stage");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_last_ff) |-> (out_col_ff == '0 && out_row_ff == '0))
      else $error("output position not wrapped after last pixel");

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bilinear_flow_warp. Planes of random size are
// loaded, then swept with flow vectors; each result is checked against a
// bilinear predictor kept inside the bench. Both handshake sides idle at
// random, with one long receiver hold-off and pauses of the sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
   import bfw_pkg::*;
();

   localparam int MAX_WIDTH      = 512;
   localparam int MAX_HEIGHT     = 512;
   localparam int PIXEL_BITS     = 16;
   localparam int FLOW_FRAC_BITS = 8;

   localparam longint FLOW_ONE   = longint'(1) << FLOW_FRAC_BITS;
   localparam longint PIXEL_MAX  = (longint'(1) << (PIXEL_BITS - 1)) - 1;
   localparam longint PIXEL_MIN  = -PIXEL_MAX - 1;
   localparam int RANDOM_ITEMS   = 250;
   localparam int SETTLE_CYCLES  = 14;
   localparam int LONG_HOLD      = 300;
   localparam int MAX_BURST      = 18;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_FLOW = 1'b1
   } warp_kind_type;

   typedef struct {
      warp_kind_type         kind;
      logic [PIXEL_BITS-1:0] pixel;
      logic [FLOW_BITS-1:0]  flow_x;
      logic [FLOW_BITS-1:0]  flow_y;
   } warp_req_type;

   typedef struct {
      logic [PIXEL_BITS-1:0] value;
      logic                  last;
   } warp_rsp_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_kind = 1'b0;
   logic [PIXEL_BITS-1:0]     req_pixel_value = '0;
   logic signed [FLOW_BITS-1:0] req_flow_x = '0;
   logic signed [FLOW_BITS-1:0] req_flow_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [PIXEL_BITS-1:0]     rsp_warped_value;
   logic                      rsp_last_pixel;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   // predictor state
   logic signed [PIXEL_BITS-1:0] plane_mem [MAX_WIDTH*MAX_HEIGHT];
   logic [CFG_BITS-1:0] cfg_width  = DIM_RESET;
   logic [CFG_BITS-1:0] cfg_height = DIM_RESET;
   int load_ptr = 0;
   int out_col  = 0;
   int out_row  = 0;

   warp_req_type pending_reqs [$];
   warp_rsp_type predicted_px [$];
   warp_req_type held_req;

   int  fault_count   = 0;
   int  queued_items  = 0;
   int  send_gap      = 0;
   int  recv_gap      = 0;
   int  send_gap_pct  = 0;
   int  recv_gap_pct  = 0;
   int  hold_left     = 0;
   bit  long_hold_req = 1'b0;
   bit  hold_done     = 1'b0;
   bit  calm          = 1'b0;

   bilinear_flow_warp #(
      .MAX_WIDTH      (MAX_WIDTH),
      .MAX_HEIGHT     (MAX_HEIGHT),
      .PIXEL_BITS     (PIXEL_BITS),
      .FLOW_FRAC_BITS (FLOW_FRAC_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_pixel_value  (req_pixel_value),
      .req_flow_x       (req_flow_x),
      .req_flow_y       (req_flow_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_warped_value (rsp_warped_value),
      .rsp_last_pixel   (rsp_last_pixel),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // bilinear predictor
   // ---------------------------------------------------------------------
   function automatic int span(input logic [CFG_BITS-1:0] v, input int lim);
      if (v == 0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
   endfunction

   function automatic longint clamp_to(input longint v, input longint hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic predict_warp(input warp_req_type item);
      int w, h, total, addr;
      longint sx, sy, x0, y0, fa, fb, cx0, cx1, cy0, cy1;
      longint p00, p01, p10, p11, r0, r1, acc;
      warp_rsp_type res;
      w = span(cfg_width, MAX_WIDTH);
      h = span(cfg_height, MAX_HEIGHT);
      if (item.kind == KIND_LOAD) begin
         total = w * h;
         addr = (load_ptr < total) ? load_ptr : 0;
         plane_mem[addr] = item.pixel;
         load_ptr = (addr + 1 >= total) ? 0 : addr + 1;
      end else begin
         if (out_col >= w) out_col = 0;
         if (out_row >= h) out_row = 0;
         sx = longint'(out_col) * FLOW_ONE + longint'($signed(item.flow_x));
         sy = longint'(out_row) * FLOW_ONE + longint'($signed(item.flow_y));
         x0 = sx >>> FLOW_FRAC_BITS;
         y0 = sy >>> FLOW_FRAC_BITS;
         fa = sx - x0 * FLOW_ONE;
         fb = sy - y0 * FLOW_ONE;
         cx0 = clamp_to(x0, w - 1);
         cx1 = clamp_to(x0 + 1, w - 1);
         cy0 = clamp_to(y0, h - 1);
         cy1 = clamp_to(y0 + 1, h - 1);
         p00 = plane_mem[cy0 * w + cx0];
         p01 = plane_mem[cy0 * w + cx1];
         p10 = plane_mem[cy1 * w + cx0];
         p11 = plane_mem[cy1 * w + cx1];
         r0 = p00 * (FLOW_ONE - fa) + p01 * fa;
         r1 = p10 * (FLOW_ONE - fa) + p11 * fa;
         acc = r0 * (FLOW_ONE - fb) + r1 * fb
               + (longint'(1) << (2 * FLOW_FRAC_BITS - 1));
         acc = acc >>> (2 * FLOW_FRAC_BITS);
         if (acc > PIXEL_MAX) acc = PIXEL_MAX;
         else if (acc < PIXEL_MIN) acc = PIXEL_MIN;
         res.value = PIXEL_BITS'(acc);
         res.last  = (out_col == w - 1) && (out_row == h - 1);
         predicted_px.push_back(res);
         if (out_col + 1 >= w) begin
            out_col = 0;
            out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
         end else begin
            out_col++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : driver
      warp_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) predict_warp(held_req);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               item = pending_reqs.pop_front();
               held_req = item;
               req_valid       <= 1'b1;
               req_kind        <= item.kind;
               req_pixel_value <= item.pixel;
               req_flow_x      <= item.flow_x;
               req_flow_y      <= item.flow_y;
               if (!calm && $urandom_range(0, 99) < send_gap_pct)
                  send_gap = $urandom_range(1, MAX_BURST);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // long receiver hold-off, started once a result is on offer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (long_hold_req && !hold_done && rsp_valid) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // result monitor
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      warp_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_px.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: unexpected result warped_value %h last_pixel %b",
                           $realtime, rsp_warped_value, rsp_last_pixel);
            end else begin
               want = predicted_px.pop_front();
               if (rsp_warped_value !== want.value || rsp_last_pixel !== want.last) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("%0t: warped_value exp %h got %h, last_pixel exp %b got %b",
                              $realtime, want.value, rsp_warped_value,
                              want.last, rsp_last_pixel);
               end
            end
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < recv_gap_pct) begin
            recv_gap = $urandom_range(1, MAX_BURST) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   function automatic logic [PIXEL_BITS-1:0] rand_pixel();
      case ($urandom_range(0, 15))
         0:       return {1'b1, {(PIXEL_BITS-1){1'b0}}};
         1:       return {1'b0, {(PIXEL_BITS-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return PIXEL_BITS'($urandom);
      endcase
   endfunction

   // displacement reaching a little past either edge of a dimension of n
   function automatic logic [FLOW_BITS-1:0] rand_shift(input int n);
      int d;
      d = int'($urandom_range(0, 2 * n + 2)) - (n + 1);
      case ($urandom_range(0, 19))
         0:       return {1'b1, {(FLOW_BITS-1){1'b0}}};
         1:       return {1'b0, {(FLOW_BITS-1){1'b1}}};
         2, 3:    return FLOW_BITS'($urandom);
         default: return FLOW_BITS'(d * (1 << FLOW_FRAC_BITS)
                                    + int'($urandom_range(0, (1 << FLOW_FRAC_BITS) - 1)));
      endcase
   endfunction

   task automatic queue_load(input logic [PIXEL_BITS-1:0] px);
      warp_req_type item;
      item.kind   = KIND_LOAD;
      item.pixel  = px;
      item.flow_x = FLOW_BITS'($urandom);
      item.flow_y = FLOW_BITS'($urandom);
      pending_reqs.push_back(item);
      queued_items++;
   endtask

   task automatic queue_flow(input logic [FLOW_BITS-1:0] fx, input logic [FLOW_BITS-1:0] fy);
      warp_req_type item;
      item.kind   = KIND_FLOW;
      item.pixel  = PIXEL_BITS'($urandom);
      item.flow_x = fx;
      item.flow_y = fy;
      pending_reqs.push_back(item);
      queued_items++;
   endtask

   task automatic queue_plane();
      repeat (span(cfg_width, MAX_WIDTH) * span(cfg_height, MAX_HEIGHT))
         queue_load(rand_pixel());
   endtask

   // idle point: nothing queued, nothing in flight, loads given time to finish
   task automatic drain();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || predicted_px.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_sweep(input int n_flows, input bit may_pause);
      for (int k = 0; k < n_flows; k++) begin
         if ($urandom_range(0, 9) == 0) queue_load(rand_pixel());
         queue_flow(rand_shift(span(cfg_width, MAX_WIDTH)),
                    rand_shift(span(cfg_height, MAX_HEIGHT)));
         if (may_pause && k == n_flows / 2) drain();
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == REG_FRAME_WIDTH) cfg_width = data;
      else if (idx == REG_FRAME_HEIGHT) cfg_height = data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [PIXEL_BITS-1:0] seed_px [9];
      int start_items, phase;
      seed_px = '{16'h0000, 16'h0001, 16'h7FFF,
                  16'hFFFF, 16'h0000, 16'h8000,
                  16'h1234, 16'hEDCC, 16'h4000};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero dimensions act as one; spare indexes are ignored
      write_csr(REG_FRAME_WIDTH, '0);
      write_csr(REG_FRAME_HEIGHT, '0);
      write_csr(REG_SPARE_2, '1);
      write_csr(REG_SPARE_3, 10'h155);
      queue_load(16'h8000);
      queue_flow(20'h80000, 20'h7FFFF);
      queue_flow(20'h7FFFF, 20'h80000);
      queue_load(16'h7FFF);
      queue_flow(20'h00080, 20'hFFF80);
      drain();

      // 3x3: rounding of halves both signs, clamping, then positions left
      // past the end by a shrink to 1x2
      write_csr(REG_FRAME_WIDTH, 10'd3);
      write_csr(REG_FRAME_HEIGHT, 10'd3);
      foreach (seed_px[i]) queue_load(seed_px[i]);
      queue_flow(20'h00080, 20'h00000);
      queue_flow(20'h00040, 20'h00040);
      queue_flow(20'h00100, 20'h00000);
      queue_flow(20'h00080, 20'h00000);
      queue_flow(20'hFFF80, 20'hFFF80);
      queue_flow(20'h000FF, 20'h000FF);
      queue_flow(20'hFFE00, 20'h80000);
      repeat (5) queue_load(rand_pixel());
      drain();
      write_csr(REG_FRAME_WIDTH, 10'd1);
      write_csr(REG_FRAME_HEIGHT, 10'd2);
      queue_load(16'h2000);
      queue_load(16'hE000);
      queue_flow(20'h00000, 20'h00080);
      queue_flow(20'h00000, 20'h00080);
      drain();

      // widest row (width above the maximum)
      send_gap_pct = 10;
      recv_gap_pct = 10;
      write_csr(REG_FRAME_WIDTH, 10'h3FF);
      write_csr(REG_FRAME_HEIGHT, 10'd1);
      queue_plane();
      queue_sweep(40, 1'b0);
      drain();

      start_items = queued_items;
      phase = 0;
      while (queued_items - start_items < RANDOM_ITEMS) begin
         if (queued_items - start_items > RANDOM_ITEMS * 4 / 5) calm = 1'b1;
         send_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         recv_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         case ($urandom_range(0, 9))
            0: begin
               write_csr(REG_FRAME_WIDTH, '0);
               write_csr(REG_FRAME_HEIGHT, CFG_BITS'($urandom_range(1, 8)));
            end
            1: begin
               write_csr(REG_FRAME_WIDTH, CFG_BITS'($urandom_range(10, 40)));
               write_csr(REG_FRAME_HEIGHT, CFG_BITS'($urandom_range(1, 3)));
            end
            default: begin
               write_csr(REG_FRAME_WIDTH, CFG_BITS'($urandom_range(1, 9)));
               write_csr(REG_FRAME_HEIGHT, CFG_BITS'($urandom_range(1, 9)));
            end
         endcase
         if (phase == 1) long_hold_req = 1'b1;
         queue_plane();
         queue_sweep($urandom_range(10, 60), $urandom_range(0, 2) == 0);
         drain();
         phase++;
      end

      calm = 1'b1;
      drain();
      if (fault_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
